// ===== src/mbrf_pkg.sv =====
// Shared types and constants for the multichannel block ring FIFO.
// No dependencies; every other file of the block imports this package.
package mbrf_pkg;

    localparam int LEN_W    = 10;
    localparam int SAMPLE_W = 64;

    // Request direction codes carried in the func field
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    // Descriptor queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Per-request control that travels with the slot address and frame data
    typedef struct packed {
        logic             is_pull;
        logic             ok;
        logic             block_end;
        logic [LEN_W-1:0] avail_read;
        logic [LEN_W-1:0] avail_write;
    } mbrf_ctrl_t;

endpackage

// ===== src/mbrf_req_if.sv =====
// Request channel: valid/ready handshake plus one frame request.
// Depends on mbrf_pkg for field widths.
interface mbrf_req_if;
    import mbrf_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic                start_block;
    logic [LEN_W-1:0]    block_len;
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;

    modport source (
        output valid, func, start_block, block_len, sample_ch0, sample_ch1,
        input  ready
    );
    modport sink (
        input  valid, func, start_block, block_len, sample_ch0, sample_ch1,
        output ready
    );
endinterface

// ===== src/mbrf_rsp_if.sv =====
// Response channel: valid/ready handshake plus one result per request.
// Depends on mbrf_pkg for field widths.
interface mbrf_rsp_if;
    import mbrf_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [SAMPLE_W-1:0] out_ch0;
    logic [SAMPLE_W-1:0] out_ch1;
    logic                block_end;
    logic [LEN_W-1:0]    avail_read;
    logic [LEN_W-1:0]    avail_write;

    modport source (
        output valid, ok, out_ch0, out_ch1, block_end, avail_read, avail_write,
        input  ready
    );
    modport sink (
        input  valid, ok, out_ch0, out_ch1, block_end, avail_read, avail_write,
        output ready
    );
endinterface

// ===== src/mbrf_front.sv =====
// Front end: accepts requests, tracks push/pull blocks, pointers and fill count.
// Depends on mbrf_pkg and mbrf_req_if; feeds descriptors to mbrf_queue.
module mbrf_front #(
    parameter int SLOTS = 1024,
    parameter int PW    = 10,
    parameter int LW    = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    mbrf_req_if.sink            req,
    input  logic                q_full,
    output logic                q_push,
    output mbrf_pkg::mbrf_ctrl_t q_ctrl,
    output logic [PW-1:0]       q_addr,
    output logic [LW-1:0]       q_data
);
    import mbrf_pkg::*;

    localparam int XW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);
    localparam logic [XW-1:0] CAP_X   = XW'(SLOTS - 1);

    logic [PW-1:0]    rp_reg, rp_next, wp_reg, wp_next, cnt_reg, cnt_next;
    logic             push_open_reg, push_open_next, pull_open_reg, pull_open_next;
    logic             push_adm_reg, push_adm_next, pull_adm_reg, pull_adm_next;
    logic [LEN_W-1:0] push_rem_reg, push_rem_next, pull_rem_reg, pull_rem_next;
    logic [LEN_W-1:0] push_off_reg, push_off_next, pull_off_reg, pull_off_next;

    logic             accept, is_pull;
    logic             eff_open, eff_adm, new_open, new_adm;
    logic [LEN_W-1:0] eff_rem, eff_off, new_rem, new_off, off_inc, rem_dec;
    logic             ok, bend, commit;
    logic [XW-1:0]    base_x, avail_x, len_x, slot_sum, cmt_sum, cnt_x, cnt_sum;
    logic [PW-1:0]    slot, cmt_ptr;

    assign accept  = req.valid & req.ready;
    assign is_pull = (req.func == FUNC_PULL);
    assign req.ready = ~q_full;

    // Block bookkeeping for the direction of the current request
    always_comb
    begin
        eff_open = is_pull ? pull_open_reg : push_open_reg;
        eff_adm  = is_pull ? pull_adm_reg  : push_adm_reg;
        eff_rem  = is_pull ? pull_rem_reg  : push_rem_reg;
        eff_off  = is_pull ? pull_off_reg  : push_off_reg;
        base_x   = XW'(is_pull ? rp_reg : wp_reg);
        cnt_x    = XW'(cnt_reg);
        avail_x  = is_pull ? cnt_x : (CAP_X - cnt_x);
        len_x    = XW'(req.block_len);
        bend     = 1'b0;
        ok       = 1'b0;
        commit   = 1'b0;
        if (req.start_block)
        begin
            eff_open = 1'b0;
            if (req.block_len == '0)
            begin
                bend = 1'b1;
            end
            else
            begin
                eff_open = 1'b1;
                eff_adm  = (avail_x >= len_x);
                eff_rem  = req.block_len;
                eff_off  = '0;
            end
        end
        off_inc  = eff_off + 1'b1;
        rem_dec  = eff_rem - 1'b1;
        new_open = eff_open;
        new_adm  = eff_adm;
        new_rem  = eff_rem;
        new_off  = eff_off;
        if (eff_open)
        begin
            ok      = eff_adm;
            new_off = off_inc;
            new_rem = rem_dec;
            if (rem_dec == '0)
            begin
                bend     = 1'b1;
                commit   = eff_adm;
                new_open = 1'b0;
                new_adm  = 1'b0;
                new_off  = '0;
            end
        end
    end

    // Slot of this frame and pointer after commit, both wrapped once
    always_comb
    begin
        slot_sum = base_x + XW'(eff_off);
        if (slot_sum >= SLOTS_X)
        begin
            slot_sum = slot_sum - SLOTS_X;
        end
        slot = slot_sum[PW-1:0];
        cmt_sum = base_x + XW'(off_inc);
        if (cmt_sum >= SLOTS_X)
        begin
            cmt_sum = cmt_sum - SLOTS_X;
        end
        cmt_ptr = cmt_sum[PW-1:0];
    end

    // Register next values
    always_comb
    begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        push_open_next = push_open_reg;
        push_adm_next  = push_adm_reg;
        push_rem_next  = push_rem_reg;
        push_off_next  = push_off_reg;
        pull_open_next = pull_open_reg;
        pull_adm_next  = pull_adm_reg;
        pull_rem_next  = pull_rem_reg;
        pull_off_next  = pull_off_reg;
        cnt_sum        = is_pull ? (cnt_x - XW'(off_inc)) : (cnt_x + XW'(off_inc));
        if (accept)
        begin
            if (is_pull)
            begin
                pull_open_next = new_open;
                pull_adm_next  = new_adm;
                pull_rem_next  = new_rem;
                pull_off_next  = new_off;
                if (commit)
                begin
                    rp_next = cmt_ptr;
                end
            end
            else
            begin
                push_open_next = new_open;
                push_adm_next  = new_adm;
                push_rem_next  = new_rem;
                push_off_next  = new_off;
                if (commit)
                begin
                    wp_next = cmt_ptr;
                end
            end
            if (commit)
            begin
                cnt_next = cnt_sum[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            push_open_reg <= 1'b0;
            push_adm_reg  <= 1'b0;
            push_rem_reg  <= '0;
            push_off_reg  <= '0;
            pull_open_reg <= 1'b0;
            pull_adm_reg  <= 1'b0;
            pull_rem_reg  <= '0;
            pull_off_reg  <= '0;
        end
        else
        begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            push_open_reg <= push_open_next;
            push_adm_reg  <= push_adm_next;
            push_rem_reg  <= push_rem_next;
            push_off_reg  <= push_off_next;
            pull_open_reg <= pull_open_next;
            pull_adm_reg  <= pull_adm_next;
            pull_rem_reg  <= pull_rem_next;
            pull_off_reg  <= pull_off_next;
        end
    end

    // Descriptor toward the back end; counts reflect state after this request
    logic [XW-1:0] cnt_after_x, free_after_x;
    assign cnt_after_x  = XW'(cnt_next);
    assign free_after_x = CAP_X - cnt_after_x;

    assign q_push              = accept;
    assign q_addr              = slot;
    assign q_ctrl.is_pull      = is_pull;
    assign q_ctrl.ok           = ok;
    assign q_ctrl.block_end    = bend;
    assign q_ctrl.avail_read   = cnt_after_x[LEN_W-1:0];
    assign q_ctrl.avail_write  = free_after_x[LEN_W-1:0];

    generate
        if (LW > SAMPLE_W)
        begin : g_two_lanes
            assign q_data = {req.sample_ch1, req.sample_ch0};
        end
        else
        begin : g_one_lane
            assign q_data = req.sample_ch0;
        end
    endgenerate

endmodule

// ===== src/mbrf_queue.sv =====
// Short in-order descriptor queue between the front and back ends.
// Depends on mbrf_pkg for the control struct and depth constants.
module mbrf_queue #(
    parameter int PW = 10,
    parameter int LW = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mbrf_pkg::mbrf_ctrl_t push_ctrl,
    input  logic [PW-1:0]        push_addr,
    input  logic [LW-1:0]        push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output mbrf_pkg::mbrf_ctrl_t head_ctrl,
    output logic [PW-1:0]        head_addr,
    output logic [LW-1:0]        head_data
);
    import mbrf_pkg::*;

    mbrf_ctrl_t        ctrl_q [QUEUE_DEPTH];
    logic [PW-1:0]     addr_q [QUEUE_DEPTH];
    logic [LW-1:0]     data_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    assign head_ctrl = ctrl_q[rd_ptr_reg];
    assign head_addr = addr_q[rd_ptr_reg];
    assign head_data = data_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_q[wr_ptr_reg] <= push_ctrl;
            addr_q[wr_ptr_reg] <= push_addr;
            data_q[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/mbrf_back.sv =====
// Back end: frame store, one write or registered read per request, output register.
// Depends on mbrf_pkg and mbrf_rsp_if; drains mbrf_queue.
module mbrf_back #(
    parameter int SLOTS = 1024,
    parameter int PW    = 10,
    parameter int LW    = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  mbrf_pkg::mbrf_ctrl_t q_ctrl,
    input  logic [PW-1:0]        q_addr,
    input  logic [LW-1:0]        q_data,
    mbrf_rsp_if.source           rsp
);
    import mbrf_pkg::*;

    logic [LW-1:0] frame_mem [SLOTS];
    logic [LW-1:0] rd_data_reg;
    mbrf_ctrl_t    ctrl_reg;
    logic          valid_reg, valid_next;
    logic          show;

    // Advance when the output register is free or being taken this cycle
    assign q_pop      = ~q_empty & (~valid_reg | rsp.ready);
    assign valid_next = q_pop | (valid_reg & ~rsp.ready);

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_ctrl.is_pull && q_ctrl.ok)
        begin
            frame_mem[q_addr] <= q_data;
        end
        if (q_pop)
        begin
            rd_data_reg <= frame_mem[q_addr];
            ctrl_reg    <= q_ctrl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign show            = ctrl_reg.is_pull & ctrl_reg.ok;
    assign rsp.valid       = valid_reg;
    assign rsp.ok          = ctrl_reg.ok;
    assign rsp.block_end   = ctrl_reg.block_end;
    assign rsp.avail_read  = ctrl_reg.avail_read;
    assign rsp.avail_write = ctrl_reg.avail_write;
    assign rsp.out_ch0     = show ? rd_data_reg[SAMPLE_W-1:0] : '0;

    generate
        if (LW > SAMPLE_W)
        begin : g_two_lanes
            assign rsp.out_ch1 = show ? rd_data_reg[2*SAMPLE_W-1:SAMPLE_W] : '0;
        end
        else
        begin : g_one_lane
            assign rsp.out_ch1 = '0;
        end
    endgenerate

endmodule

// ===== src/multichannel_block_ring_fifo.sv =====
// Top level of the multichannel block ring FIFO: front, descriptor queue, back.
// Depends on mbrf_pkg, mbrf_req_if, mbrf_rsp_if, mbrf_front, mbrf_queue, mbrf_back.
//
// Usage:
//   req carries one frame request: func selects push or pull, start_block with
//   block_len opens a block, sample_ch0/1 carry the pushed frame. rsp returns
//   exactly one result per request, in order: ok, the pulled samples (zero
//   unless an admitted pull), block_end, and the committed avail_read and
//   avail_write counts after the request.
//   A block is admitted on its first request if the committed fill (pull) or
//   free (push) count covers its length; pointers move only on its last frame.
//   A request passes the descriptor queue and the back-end output register;
//   one request per cycle is sustained while the receiver takes results, set
//   by the single-port frame store taking one write or one read per cycle.
//   The front end tracks blocks and pointers; a 4-entry queue lets it keep
//   accepting while the back end is held by a stalled receiver. When the queue
//   fills, req.ready drops until the receiver takes results again.
//   Reset clears pointers, block state, the queue and the output valid; frame
//   store contents are left as they are (only written frames are ever pulled).
module multichannel_block_ring_fifo #(
    parameter int SLOTS    = 1024,
    parameter int CHANNELS = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    mbrf_req_if.sink   req,
    mbrf_rsp_if.source rsp
);
    import mbrf_pkg::*;

    // Only channels 0 and 1 are ever reported
    localparam int LANES = (CHANNELS > 1) ? 2 : 1;
    localparam int LW    = LANES * SAMPLE_W;
    localparam int PW    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam logic [LEN_W-1:0] CAP_LOW = LEN_W'(SLOTS - 1);

    logic          q_push, q_full, q_pop, q_empty;
    mbrf_ctrl_t    in_ctrl, head_ctrl;
    logic [PW-1:0] in_addr, head_addr;
    logic [LW-1:0] in_data, head_data;

    // Classify requests and update block/pointer state
    mbrf_front #(
        .SLOTS (SLOTS),
        .PW    (PW),
        .LW    (LW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_ctrl (in_ctrl),
        .q_addr (in_addr),
        .q_data (in_data)
    );

    // Decouple front from a stalled back end
    mbrf_queue #(
        .PW (PW),
        .LW (LW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_ctrl (in_ctrl),
        .push_addr (in_addr),
        .push_data (in_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_ctrl (head_ctrl),
        .head_addr (head_addr),
        .head_data (head_data)
    );

    // Access the frame store and hold the result for the receiver
    mbrf_back #(
        .SLOTS (SLOTS),
        .PW    (PW),
        .LW    (LW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_ctrl  (head_ctrl),
        .q_addr  (head_addr),
        .q_data  (head_data),
        .rsp     (rsp)
    );

    // A full queue must never take another descriptor
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("descriptor queue overflow");

    // The back end never drains an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("descriptor queue underflow");

    // Committed fill and free counts always add up to the capacity
    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (LEN_W'(rsp.avail_read + rsp.avail_write) == CAP_LOW))
        else $error("avail counts inconsistent");

    // A refused or unmatched request returns no sample data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.out_ch0 == '0 && rsp.out_ch1 == '0))
        else $error("sample data on refused request");

endmodule

// ===== tb/sv/multichannel_block_ring_fifo_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for multichannel_block_ring_fifo: block push/pull requests in,
// ordered results checked against a ring FIFO predictor. Depends on mbrf_pkg and the
// mbrf_req_if / mbrf_rsp_if interfaces.
module multichannel_block_ring_fifo_test;
    import mbrf_pkg::*;

    localparam int SLOTS       = 1024;
    localparam int CHANNELS    = 2;
    localparam int HALF_PERIOD = 6;
    localparam int ITEMS       = 1650;
    localparam int LIMIT       = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam logic [LEN_W-1:0]    LEN_MAX  = '1;
    localparam logic [SAMPLE_W-1:0] ALL_ONES = '1;
    localparam logic [SAMPLE_W-1:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [SAMPLE_W-1:0] ALT_5    = 64'h5555_5555_5555_5555;

    // One frame request as the sender sees it
    typedef struct packed {
        logic                func;
        logic                start_block;
        logic [LEN_W-1:0]    block_len;
        logic [SAMPLE_W-1:0] sample_ch0;
        logic [SAMPLE_W-1:0] sample_ch1;
    } frame_req_t;

    // One result as the receiver sees it
    typedef struct packed {
        logic                ok;
        logic [SAMPLE_W-1:0] out_ch0;
        logic [SAMPLE_W-1:0] out_ch1;
        logic                block_end;
        logic [LEN_W-1:0]    avail_read;
        logic [LEN_W-1:0]    avail_write;
    } frame_rsp_t;

    // Ring FIFO predictor plus the queue of results it still owes.
    class ring_fifo_board;
        bit [SAMPLE_W-1:0] ch0_frames [SLOTS];
        bit [SAMPLE_W-1:0] ch1_frames [SLOTS];
        int unsigned rd_ptr;
        int unsigned wr_ptr;
        // Block trackers indexed by direction: 0 push, 1 pull
        bit          blk_open [2];
        bit          blk_admitted [2];
        int unsigned blk_remaining [2];
        int unsigned blk_offset [2];
        frame_rsp_t  due_results [$];
        int          errors;

        function int unsigned filled();
            return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + SLOTS - rd_ptr;
        endfunction

        function int unsigned free_slots();
            return (wr_ptr >= rd_ptr) ? SLOTS - wr_ptr + rd_ptr - 1 : rd_ptr - wr_ptr - 1;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Advance the predictor by one accepted request and queue its result.
        function void note_request(frame_req_t r);
            frame_rsp_t  e;
            bit          pull;
            int unsigned slot;
            e = '0;
            pull = (r.func == FUNC_PULL);
            if (r.start_block) begin
                // A new start abandons whatever block of this direction is open
                blk_open[pull] = 1'b0;
                if (r.block_len == 0) begin
                    e.block_end = 1'b1;
                end
                else begin
                    blk_open[pull]      = 1'b1;
                    blk_admitted[pull]  = (pull ? filled() : free_slots()) >= r.block_len;
                    blk_remaining[pull] = r.block_len;
                    blk_offset[pull]    = 0;
                end
            end
            if (blk_open[pull]) begin
                if (blk_admitted[pull]) begin
                    slot = ((pull ? rd_ptr : wr_ptr) + blk_offset[pull]) % SLOTS;
                    e.ok = 1'b1;
                    if (pull) begin
                        e.out_ch0 = ch0_frames[slot];
                        e.out_ch1 = (CHANNELS > 1) ? ch1_frames[slot] : '0;
                    end
                    else begin
                        ch0_frames[slot] = r.sample_ch0;
                        ch1_frames[slot] = r.sample_ch1;
                    end
                end
                blk_offset[pull]    = (blk_offset[pull] + 1) & LEN_MAX;
                blk_remaining[pull] = (blk_remaining[pull] - 1) & LEN_MAX;
                if (blk_remaining[pull] == 0) begin
                    e.block_end = 1'b1;
                    // Commit the pointer only for an admitted block
                    if (blk_admitted[pull]) begin
                        if (pull)
                            rd_ptr = (rd_ptr + blk_offset[pull]) % SLOTS;
                        else
                            wr_ptr = (wr_ptr + blk_offset[pull]) % SLOTS;
                    end
                    blk_open[pull]     = 1'b0;
                    blk_admitted[pull] = 1'b0;
                    blk_offset[pull]   = 0;
                end
            end
            e.avail_read  = LEN_W'(filled());
            e.avail_write = LEN_W'(free_slots());
            due_results.push_back(e);
        endfunction

        function void check_field(string name, logic [SAMPLE_W-1:0] want,
                                  logic [SAMPLE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(frame_rsp_t a);
            frame_rsp_t e;
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: ok=%0b block_end=%0b", a.ok,
                       a.block_end);
                errors++;
                return;
            end
            e = due_results.pop_front();
            check_field("ok", e.ok, a.ok);
            check_field("out_ch0", e.out_ch0, a.out_ch0);
            check_field("out_ch1", e.out_ch1, a.out_ch1);
            check_field("block_end", e.block_end, a.block_end);
            check_field("avail_read", e.avail_read, a.avail_read);
            check_field("avail_write", e.avail_write, a.avail_write);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mbrf_req_if req_ch ();
    mbrf_rsp_if rsp_ch ();

    multichannel_block_ring_fifo #(
        .SLOTS    (SLOTS),
        .CHANNELS (CHANNELS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    ring_fifo_board board = new();

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int sent_items = 0;
    int cycle_count = 0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Hard stop: end the run as a failure if the limit is reached.
    initial
    begin : watchdog
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Sample values: mostly random, with the all-ones and all-zero extremes mixed in.
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return ALL_ONES;
        if (pick == 1)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // Block length: mostly short, sometimes long or around the current committed
    // count, so that both admission and refusal come up, with an exact-fit length now and then.
    function automatic int unsigned pick_len(int unsigned avail);
        int unsigned pick;
        int          v;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 16);
        if (pick < 88)
            return $urandom_range(1, 64);
        if (pick < 97)
        begin
            v = int'(avail) + int'($urandom_range(0, 2)) - 1;
            if (v < 1)
                v = 1;
            if (v > LEN_MAX)
                v = LEN_MAX;
            return v;
        end
        return $urandom_range(65, LEN_MAX);
    endfunction

    // Frames actually sent for a block: long blocks and a share of the
    // others are cut short, and the next start abandons them.
    function automatic int unsigned frames_for(int unsigned len);
        if (len > 64)
            return $urandom_range(1, 8);
        if (len > 1 && $urandom_range(0, 9) == 0)
            return $urandom_range(1, len - 1);
        return len;
    endfunction

    // Drive one request and hold it until the block takes it; an idle
    // burst may come first with valid low.
    task automatic send_item(logic f, logic st, logic [LEN_W-1:0] len,
                             logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s1);
        frame_req_t r;
        r = '{func: f, start_block: st, block_len: len, sample_ch0: s0, sample_ch1: s1};
        if (tx_idle_en && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.start_block <= st;
        req_ch.block_len   <= len;
        req_ch.sample_ch0  <= s0;
        req_ch.sample_ch1  <= s1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(r);
        sent_items++;
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Send a push block and a pull block with their frames merged at random;
    // either may be empty. Non-start frames carry a random, ignored length.
    task automatic send_blocks(int unsigned push_len, int unsigned push_frames,
                               int unsigned pull_len, int unsigned pull_frames);
        int unsigned push_done;
        int unsigned pull_done;
        bit          take_pull;
        push_done = 0;
        pull_done = 0;
        while (push_done < push_frames || pull_done < pull_frames)
        begin
            take_pull = (push_done >= push_frames) ||
                        (pull_done < pull_frames && $urandom_range(0, 1) == 1);
            if (take_pull)
            begin
                send_item(FUNC_PULL, pull_done == 0,
                          (pull_done == 0) ? LEN_W'(pull_len) : LEN_W'($urandom_range(0, LEN_MAX)),
                          rand_sample(), rand_sample());
                pull_done++;
            end
            else
            begin
                send_item(FUNC_PUSH, push_done == 0,
                          (push_done == 0) ? LEN_W'(push_len) : LEN_W'($urandom_range(0, LEN_MAX)),
                          rand_sample(), rand_sample());
                push_done++;
            end
        end
    endtask

    // Directed opening: stray requests, empty blocks, refusal on an empty
    // ring, sample extremes, restarts of open blocks, interleaved directions.
    task automatic run_directed();
        // Stray requests with no open block in either direction
        send_item(FUNC_PULL, 1'b0, '0, ALL_ONES, ALL_ONES);
        send_item(FUNC_PUSH, 1'b0, LEN_MAX, ALL_ONES, ALL_ONES);
        // Zero-length starts: refused empty blocks
        send_item(FUNC_PUSH, 1'b1, '0, ALL_ONES, '0);
        send_item(FUNC_PULL, 1'b1, '0, '0, ALL_ONES);
        // Pull on an empty ring is refused
        send_item(FUNC_PULL, 1'b1, 10'd1, '0, '0);
        // Push four frames of extreme patterns and commit them
        send_item(FUNC_PUSH, 1'b1, 10'd4, ALL_ONES, ALL_ONES);
        send_item(FUNC_PUSH, 1'b0, '0, '0, '0);
        send_item(FUNC_PUSH, 1'b0, LEN_MAX, ALT_A, ALT_5);
        send_item(FUNC_PUSH, 1'b0, '0, ALT_5, ALT_A);
        // Maximum length push is refused, then restarted by a short block
        send_item(FUNC_PUSH, 1'b1, LEN_MAX, ALL_ONES, '0);
        send_item(FUNC_PUSH, 1'b1, 10'd2, '0, ALL_ONES);
        send_item(FUNC_PUSH, 1'b0, '0, ALT_A, ALT_A);
        // Interleave a pull block with a push block
        send_item(FUNC_PULL, 1'b1, 10'd3, ALL_ONES, ALL_ONES);
        send_item(FUNC_PUSH, 1'b1, 10'd2, ALT_5, ALT_5);
        send_item(FUNC_PULL, 1'b0, '0, '0, '0);
        send_item(FUNC_PUSH, 1'b0, '0, 64'h8000_0000_0000_0001, 64'h1);
        send_item(FUNC_PULL, 1'b0, LEN_MAX, ALT_A, ALT_5);
        // Restart an open pull block before it ends
        send_item(FUNC_PULL, 1'b1, 10'd4, '0, '0);
        send_item(FUNC_PULL, 1'b1, 10'd2, '0, '0);
        send_item(FUNC_PULL, 1'b0, '0, '0, '0);
        // Stray pull once the block has closed
        send_item(FUNC_PULL, 1'b0, 10'd7, ALL_ONES, '0);
        // Restart an open push block; the new one overwrites its first slot
        send_item(FUNC_PUSH, 1'b1, 10'd3, ALL_ONES, ALL_ONES);
        send_item(FUNC_PUSH, 1'b1, 10'd1, ALT_A, '0);
    endtask

    // Random part: mostly well-formed blocks with random content, some
    // paired across directions, plus stray requests, empty and cut blocks.
    task automatic run_random();
        int unsigned kind;
        bit          pull_first;
        bit          paired;
        int unsigned push_len;
        int unsigned push_frames;
        int unsigned pull_len;
        int unsigned pull_frames;
        while (sent_items < ITEMS)
        begin
            // Drop idling on both sides for the last stretch of the run
            if (sent_items >= ITEMS - 200)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    tx_idle_en = !tx_idle_en;
                if ($urandom_range(0, 31) == 0)
                    rx_idle_en = !rx_idle_en;
            end
            if ($urandom_range(0, 63) == 0)
                wait_for_drain();
            kind = $urandom_range(0, 99);
            if (kind < 4)
            begin
                send_item(1'($urandom_range(0, 1)), 1'b0, LEN_W'($urandom_range(0, LEN_MAX)),
                          rand_sample(), rand_sample());
            end
            else if (kind < 7)
            begin
                send_item(1'($urandom_range(0, 1)), 1'b1, '0, rand_sample(), rand_sample());
            end
            else
            begin
                // Lean toward pull as the ring fills, toward push as it empties
                pull_first  = $urandom_range(0, SLOTS + 127) < board.filled() + 64;
                paired      = kind >= 75;
                push_len    = 0;
                push_frames = 0;
                pull_len    = 0;
                pull_frames = 0;
                if (paired || !pull_first)
                begin
                    push_len    = pick_len(board.free_slots());
                    push_frames = frames_for(push_len);
                end
                if (paired || pull_first)
                begin
                    pull_len    = pick_len(board.filled());
                    pull_frames = frames_for(pull_len);
                end
                send_blocks(push_len, push_frames, pull_len, pull_frames);
            end
        end
    endtask

    // Receiver: check each accepted result, then stall in random bursts.
    initial
    begin : rsp_side
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result('{ok: rsp_ch.ok, out_ch0: rsp_ch.out_ch0,
                                     out_ch1: rsp_ch.out_ch1, block_end: rsp_ch.block_end,
                                     avail_read: rsp_ch.avail_read,
                                     avail_write: rsp_ch.avail_write});
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 7) == 0)
                    hold = $urandom_range(1, 11);
            end
        end
    end

    initial
    begin : stimulus
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= FUNC_PUSH;
        req_ch.start_block <= 1'b0;
        req_ch.block_len   <= '0;
        req_ch.sample_ch0  <= '0;
        req_ch.sample_ch1  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        run_directed();
        // Hold the sender until the ring has answered everything so far
        wait_for_drain();
        // Drain exactly, then fill to the brim from a nonzero pointer so the
        // push wraps; one more push request must then be refused
        send_blocks(0, 0, board.filled(), board.filled());
        send_blocks(board.free_slots(), board.free_slots(), 0, 0);
        send_item(FUNC_PUSH, 1'b1, 10'd1, rand_sample(), rand_sample());
        run_random();

        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
